// ----- design/csb_pkg.sv -----
// shared types and constants for the character sprite blitter
`default_nettype none

package csb_pkg;

    // default sizes of the cell store and the largest sprite
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_SPRITE_DEF = 64;

    // character codes
    localparam logic [15:0] TRANSPARENT_CODE = 16'h2591;
    localparam logic [15:0] SPACE_CODE       = 16'h0020;

    // configuration registers
    localparam int          CFG_DATA_W  = 8;
    localparam logic        CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic        CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [7:0]  SCREEN_W_RST = 8'd80;
    localparam logic [6:0]  SCREEN_H_RST = 7'd25;

    // request operations
    typedef enum logic [1:0] {
        MODE_SPRITE = 2'd0,
        MODE_CHAR   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    // cell access decided by the address unit
    typedef struct packed {
        logic on_screen;
        logic wr;
        logic rd;
    } t_access;

endpackage

`default_nettype wire

// ----- design/char_sprite_blitter.sv -----
// top level of the character framebuffer with sprite blitter
//
// usage
// - input channel i_in_valid / o_in_ready carries one request: a sprite
//   element, a single char write, a clear, or a cell read (i_mode)
// - output channel o_out_valid / i_out_ready returns exactly one result per
//   request: o_wrote, o_read_valid and o_read_glyph
// - screen size registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data, index 0 width and index 1 height, taken in any cycle
// - one request is in flight at a time; a write result passes through S_EXEC
//   and S_DONE to the output register, a read also through S_READ (registered
//   memory data); the next request is taken once the block is back in S_IDLE
// - a clear walks the whole cell store, one cell per cycle, and its result
//   follows once the last cell is written
// - after reset the same sweep runs first: o_in_ready stays low while every
//   cell is set to a space
// - when the receiver stalls the result waits in the output register; the
//   next request is still accepted and runs up to its own result, which
//   then waits until the output register is free
`default_nettype none

module char_sprite_blitter #(
    parameter int MAX_WIDTH  = csb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SPRITE = csb_pkg::MAX_SPRITE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_pos_x,
    input  wire logic [15:0] i_pos_y,
    input  wire logic [6:0]  i_sprite_width,
    input  wire logic [6:0]  i_sprite_height,
    input  wire logic [5:0]  i_elem_row,
    input  wire logic [5:0]  i_elem_col,
    input  wire logic [15:0] i_glyph,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_wrote,
    output logic             o_read_valid,
    output logic [15:0]      o_read_glyph,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import csb_pkg::*;

    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;

    // screen size registers
    logic [7:0] r_screen_w;
    logic [6:0] r_screen_h;

    // captured request
    t_mode       r_mode;
    logic [15:0] r_pos_x;
    logic [15:0] r_pos_y;
    logic [6:0]  r_spr_w;
    logic [6:0]  r_spr_h;
    logic [5:0]  r_row;
    logic [5:0]  r_col;
    logic [15:0] r_glyph;

    // clear sweep
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_item;   // sweep started by a clear request, not by reset

    // pending result and output register
    logic        r_res_wrote;
    logic        r_res_rvalid;
    logic [15:0] r_res_glyph;
    logic        r_out_valid;
    logic        r_out_wrote;
    logic        r_out_rvalid;
    logic [15:0] r_out_glyph;

    // memory port
    logic [ADDR_W-1:0] gen_addr;
    t_access           gen_acc;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [15:0]       mem_wdata;
    logic [15:0]       mem_rdata;
    logic              clr_last;
    logic              out_free;

    csb_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SPRITE (MAX_SPRITE),
        .ADDR_W     (ADDR_W)
    ) u_addr_gen (
        .i_mode          (r_mode),
        .i_pos_x         (r_pos_x),
        .i_pos_y         (r_pos_y),
        .i_sprite_width  (r_spr_w),
        .i_sprite_height (r_spr_h),
        .i_elem_row      (r_row),
        .i_elem_col      (r_col),
        .i_glyph         (r_glyph),
        .i_screen_width  (r_screen_w),
        .i_screen_height (r_screen_h),
        .o_addr          (gen_addr),
        .o_acc           (gen_acc)
    );

    // the sweep owns the port while clearing, otherwise the request does
    always_comb begin
        mem_addr  = (r_state == S_CLEAR) ? r_clr_addr : gen_addr;
        mem_we    = (r_state == S_CLEAR) || ((r_state == S_EXEC) && gen_acc.wr);
        mem_wdata = (r_state == S_CLEAR) ? SPACE_CODE : r_glyph;
        clr_last  = (r_clr_addr == ADDR_W'(CELL_COUNT - 1));
        out_free  = !r_out_valid || i_out_ready;
    end

    csb_cell_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (16)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_screen_w  <= SCREEN_W_RST;
            r_screen_h  <= SCREEN_H_RST;
        end else begin
            // configuration writes are taken in any state
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // result taken by the receiver, unless the next one moves in
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (clr_last) begin
                        r_res_wrote  <= 1'b1;
                        r_res_rvalid <= 1'b0;
                        r_res_glyph  <= '0;
                        r_state      <= r_clr_item ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= t_mode'(i_mode);
                        r_pos_x <= i_pos_x;
                        r_pos_y <= i_pos_y;
                        r_spr_w <= i_sprite_width;
                        r_spr_h <= i_sprite_height;
                        r_row   <= i_elem_row;
                        r_col   <= i_elem_col;
                        r_glyph <= i_glyph;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_mode == MODE_CLEAR) begin
                        r_clr_addr <= '0;
                        r_clr_item <= 1'b1;
                        r_state    <= S_CLEAR;
                    end else if (r_mode == MODE_READ) begin
                        // cell data arrives from memory next cycle
                        r_res_wrote  <= 1'b0;
                        r_res_rvalid <= gen_acc.rd;
                        r_state      <= S_READ;
                    end else begin
                        r_res_wrote  <= gen_acc.wr;
                        r_res_rvalid <= 1'b0;
                        r_res_glyph  <= '0;
                        r_state      <= S_DONE;
                    end
                end
                S_READ: begin
                    r_res_glyph <= r_res_rvalid ? mem_rdata : 16'd0;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    // move the result out once the output register is free
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_wrote  <= r_res_wrote;
                        r_out_rvalid <= r_res_rvalid;
                        r_out_glyph  <= r_res_glyph;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_wrote      = r_out_wrote;
    assign o_read_valid = r_out_rvalid;
    assign o_read_glyph = r_out_glyph;

endmodule

`default_nettype wire

// ----- design/csb_cell_mem.sv -----
// single-port synchronous cell memory with registered read data
`default_nettype none

module csb_cell_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/csb_addr_gen.sv -----
// placement, clipping and cell address for one request
`default_nettype none

module csb_addr_gen #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_SPRITE = 64,
    parameter int ADDR_W     = 13
) (
    input  wire csb_pkg::t_mode  i_mode,
    input  wire logic [15:0]     i_pos_x,
    input  wire logic [15:0]     i_pos_y,
    input  wire logic [6:0]      i_sprite_width,
    input  wire logic [6:0]      i_sprite_height,
    input  wire logic [5:0]      i_elem_row,
    input  wire logic [5:0]      i_elem_col,
    input  wire logic [15:0]     i_glyph,
    input  wire logic [7:0]      i_screen_width,
    input  wire logic [6:0]      i_screen_height,
    output logic [ADDR_W-1:0]    o_addr,
    output csb_pkg::t_access     o_acc
);

    import csb_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [17:0] px_ext;
    logic [17:0] py_ext;
    logic [17:0] spr_x;
    logic [17:0] spr_y;
    logic [17:0] cx;
    logic [17:0] cy;
    logic        sprite_ok;
    logic        x_on;
    logic        y_on;
    logic        on;

    always_comb begin
        px_ext = {{2{i_pos_x[15]}}, i_pos_x};
        py_ext = {{2{i_pos_y[15]}}, i_pos_y};

        // top-left corner from the bottom-center anchor, then the element offset
        spr_x = px_ext - 18'(i_sprite_width >> 1) + 18'(i_elem_col);
        spr_y = py_ext - 18'(i_sprite_height) + 18'd1 + 18'(i_elem_row);

        sprite_ok = (i_sprite_width != 7'd0) && (i_sprite_height != 7'd0)
                 && (9'(i_sprite_width) <= 9'(MAX_SPRITE))
                 && (9'(i_sprite_height) <= 9'(MAX_SPRITE))
                 && ({1'b0, i_elem_row} < i_sprite_height)
                 && ({1'b0, i_elem_col} < i_sprite_width)
                 && (i_glyph != TRANSPARENT_CODE);

        cx = (i_mode == MODE_SPRITE) ? spr_x : px_ext;
        cy = (i_mode == MODE_SPRITE) ? spr_y : py_ext;

        // clip against both the programmed size and the store size
        x_on = !cx[17] && (cx[16:0] < 17'(i_screen_width)) && (cx[16:0] < 17'(MAX_WIDTH));
        y_on = !cy[17] && (cy[16:0] < 17'(i_screen_height))
            && (cy[16:0] < 17'(MAX_HEIGHT));
        on   = x_on && y_on;

        o_acc.on_screen = on;
        o_acc.wr = on && (((i_mode == MODE_SPRITE) && sprite_ok) || (i_mode == MODE_CHAR));
        o_acc.rd = on && (i_mode == MODE_READ);

        o_addr = ADDR_W'(ADDR_W'(cy[YW-1:0]) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(cx[XW-1:0]);
    end

endmodule

`default_nettype wire

// ----- design/csb_checker.sv -----
// port-level checks for the character sprite blitter, bound to the top level
`default_nettype none

module csb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_wrote,
    input wire logic        o_read_valid,
    input wire logic [15:0] o_read_glyph
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one request at a time: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // only a valid read carries cell data
    a_glyph_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_read_valid) |-> (o_read_glyph == 16'd0))
        else $error("cell data without a valid read");

    // a request either writes or reads, never both
    a_wr_xor_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_wrote && o_read_valid))
        else $error("result reports both a write and a read");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_glyph)
            && $stable(o_wrote) && $stable(o_read_valid)))
        else $error("stalled result changed");

endmodule

bind char_sprite_blitter csb_checker u_csb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_wrote      (o_wrote),
    .o_read_valid (o_read_valid),
    .o_read_glyph (o_read_glyph)
);

`default_nettype wire
